### rtl/core/urx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants of the UART receiver with timeouts.
// ----------------------------------------------------------------------------
package urx_pkg;

	localparam int unsigned BitTicksW  = 10;
	localparam int unsigned WaitTicksW = 16;
	localparam int unsigned ByteW      = 8;
	localparam int unsigned BitIdxW    = 4;
	localparam int unsigned ApbDataW   = 32;
	localparam int unsigned ApbAddrW   = 4;

	localparam logic [BitTicksW-1:0]  BitTicksRst  = 10'd52;
	localparam logic [BitTicksW-1:0]  HalfTicksRst = 10'd26;
	localparam logic [WaitTicksW-1:0] IdleToRst    = 16'd20000;
	localparam logic [WaitTicksW-1:0] StartGapRst  = 16'd260;

	localparam logic [BitIdxW-1:0]    DataBits     = 4'd8;
	localparam logic [WaitTicksW-1:0] TickMax      = 16'hFFFF;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_BIT_TICKS  = 2'd0,
		REG_HALF_TICKS = 2'd1,
		REG_IDLE_TO    = 2'd2,
		REG_START_GAP  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_HALF  = 3'd2,
		PH_DATA  = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		OC_GOOD      = 3'd0,
		OC_IDLE_TO   = 3'd1,
		OC_NO_START  = 3'd2,
		OC_BAD_START = 3'd3,
		OC_BAD_STOP  = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [BitTicksW-1:0]  bit_ticks;
		logic [BitTicksW-1:0]  half_bit_ticks;
		logic [WaitTicksW-1:0] idle_timeout_ticks;
		logic [WaitTicksW-1:0] start_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		outcome_t         outcome;
		logic [ByteW-1:0] data_byte;
	} res_t;

endpackage

### rtl/core/urx_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_cfg_regs
// APB register file holding the bit timing and timeout settings.
// ----------------------------------------------------------------------------
module urx_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [urx_pkg::ApbAddrW-1:0]  paddr,
	input  logic [urx_pkg::ApbDataW-1:0]  pwdata,
	output logic [urx_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready,
	output urx_pkg::cfg_t                 cfg
);

	urx_pkg::cfg_t    cfg_q;
	urx_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = urx_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_ticks          <= urx_pkg::BitTicksRst;
			cfg_q.half_bit_ticks     <= urx_pkg::HalfTicksRst;
			cfg_q.idle_timeout_ticks <= urx_pkg::IdleToRst;
			cfg_q.start_gap_ticks    <= urx_pkg::StartGapRst;
		end else if (wr_en) begin
			unique case (idx)
				urx_pkg::REG_BIT_TICKS: begin
					cfg_q.bit_ticks <= pwdata[urx_pkg::BitTicksW-1:0];
				end
				urx_pkg::REG_HALF_TICKS: begin
					cfg_q.half_bit_ticks <= pwdata[urx_pkg::BitTicksW-1:0];
				end
				urx_pkg::REG_IDLE_TO: begin
					cfg_q.idle_timeout_ticks <= pwdata[urx_pkg::WaitTicksW-1:0];
				end
				urx_pkg::REG_START_GAP: begin
					cfg_q.start_gap_ticks <= pwdata[urx_pkg::WaitTicksW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			urx_pkg::REG_BIT_TICKS: begin
				prdata[urx_pkg::BitTicksW-1:0] = cfg_q.bit_ticks;
			end
			urx_pkg::REG_HALF_TICKS: begin
				prdata[urx_pkg::BitTicksW-1:0] = cfg_q.half_bit_ticks;
			end
			urx_pkg::REG_IDLE_TO: begin
				prdata[urx_pkg::WaitTicksW-1:0] = cfg_q.idle_timeout_ticks;
			end
			urx_pkg::REG_START_GAP: begin
				prdata[urx_pkg::WaitTicksW-1:0] = cfg_q.start_gap_ticks;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/urx_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_fsm
// Receive sequencer: idle wait, start wait, start check, data bits, stop bit.
// ----------------------------------------------------------------------------
module urx_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          action,
	input  logic          line_level,
	input  urx_pkg::cfg_t cfg,
	output urx_pkg::res_t res
);

	urx_pkg::phase_t                   phase_q, phase_d;
	logic [urx_pkg::WaitTicksW-1:0]    tick_q, tick_d, tick_inc;
	logic [urx_pkg::BitIdxW-1:0]       idx_q, idx_d;
	logic [urx_pkg::ByteW-1:0]         shift_q, shift_d;
	logic                              seen_q, seen_d;
	logic [urx_pkg::WaitTicksW-1:0]    half_w, bit_w;

	assign half_w = {{(urx_pkg::WaitTicksW-urx_pkg::BitTicksW){1'b0}}, cfg.half_bit_ticks};
	assign bit_w  = {{(urx_pkg::WaitTicksW-urx_pkg::BitTicksW){1'b0}}, cfg.bit_ticks};

	// saturate at the top of the counter
	assign tick_inc = (tick_q == urx_pkg::TickMax) ? tick_q : tick_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urx_pkg::PH_IDLE;
			tick_q  <= '0;
			idx_q   <= '0;
			shift_q <= '0;
			seen_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			seen_q  <= seen_d;
		end
	end

	always_comb begin
		logic finish;
		finish        = 1'b0;
		phase_d       = phase_q;
		tick_d        = tick_q;
		idx_d         = idx_q;
		shift_d       = shift_q;
		seen_d        = seen_q;
		res.valid     = 1'b0;
		res.outcome   = urx_pkg::OC_GOOD;
		res.data_byte = '0;
		if (action) begin
			seen_d = 1'b0;
			finish = 1'b1;
		end else begin
			unique case (phase_q)
				urx_pkg::PH_START: begin
					if (line_level) begin
						if (seen_q && (tick_q >= cfg.start_gap_ticks)) begin
							finish      = 1'b1;
							res.valid   = 1'b1;
							res.outcome = urx_pkg::OC_NO_START;
						end else begin
							tick_d = tick_inc;
						end
					end else begin
						phase_d = urx_pkg::PH_HALF;
						tick_d  = '0;
					end
				end
				urx_pkg::PH_HALF: begin
					tick_d = tick_inc;
					if (tick_inc >= half_w) begin
						if (line_level) begin
							finish      = 1'b1;
							res.valid   = 1'b1;
							res.outcome = urx_pkg::OC_BAD_START;
						end else begin
							phase_d = urx_pkg::PH_DATA;
							tick_d  = '0;
							idx_d   = '0;
							shift_d = '0;
						end
					end
				end
				urx_pkg::PH_DATA: begin
					tick_d = tick_inc;
					if (tick_inc >= bit_w) begin
						shift_d[idx_q[2:0]] = shift_q[idx_q[2:0]] | line_level;
						idx_d  = idx_q + 1'b1;
						tick_d = '0;
						if (idx_d >= urx_pkg::DataBits) begin
							phase_d = urx_pkg::PH_STOP;
						end
					end
				end
				urx_pkg::PH_STOP: begin
					tick_d = tick_inc;
					if (tick_inc >= bit_w) begin
						finish    = 1'b1;
						res.valid = 1'b1;
						if (!line_level) begin
							res.outcome = urx_pkg::OC_BAD_STOP;
						end else begin
							seen_d        = 1'b1;
							res.outcome   = urx_pkg::OC_GOOD;
							res.data_byte = shift_q;
						end
					end
				end
				default: begin
					// idle wait, also taken by unused phase codes
					if (line_level) begin
						phase_d = urx_pkg::PH_START;
						tick_d  = '0;
					end else if (tick_q >= cfg.idle_timeout_ticks) begin
						finish      = 1'b1;
						res.valid   = 1'b1;
						res.outcome = urx_pkg::OC_IDLE_TO;
					end else begin
						tick_d = tick_inc;
					end
				end
			endcase
		end
		if (finish) begin
			phase_d = urx_pkg::PH_IDLE;
			tick_d  = '0;
			idx_d   = '0;
			shift_d = '0;
		end
	end

endmodule

### rtl/core/urx_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_out_reg
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module urx_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  urx_pkg::res_t res,
	output logic          room,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // [7:0] data_byte
	output logic [2:0]    m_tuser    // [2:0] outcome
);

	logic                       valid_q;
	urx_pkg::outcome_t          outcome_q;
	logic [urx_pkg::ByteW-1:0]  data_q;

	assign room     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			outcome_q <= res.outcome;
			data_q    <= res.data_byte;
		end
	end

endmodule

### rtl/core/uart_receiver_with_timeouts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_receiver_with_timeouts
// 8N1 UART receiver fed one line sample per request, with idle and start
// timeouts; reports a good byte or the reason a read failed.
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser = action, tdata[0] = line_level
// m_*       out  m_tvalid/m_tready   tuser = outcome, tdata = data_byte
// apb       in   psel/penable        4 timing registers at 0x0..0xC
//
// One request per cycle while the output register has room: a request is
// registered, then the sequencer steps on it and places any result in the
// output register.
// Reset restores the register defaults and returns to the idle wait.
// A stalled output register holds the sequencer and, through it, s_tready.
// ----------------------------------------------------------------------------
module uart_receiver_with_timeouts (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] line_level
	input  logic                          s_tuser,   // [0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] data_byte
	output logic [2:0]                    m_tuser,   // [2:0] outcome
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [urx_pkg::ApbAddrW-1:0]  paddr,
	input  logic [urx_pkg::ApbDataW-1:0]  pwdata,
	output logic [urx_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready
);

	urx_pkg::cfg_t cfg;
	urx_pkg::res_t res;
	logic          valid_s1, action_s1, line_s1;
	logic          room, step;

	assign step     = valid_s1 && room;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			line_s1   <= s_tdata[0];
		end
	end

	urx_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	urx_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.action     (action_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	urx_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives line samples and frame begins into the UART receiver with timeouts.
// Each read is predicted by a model of the read sequence, and every result
// is compared in order. A directed part covers each outcome, zero periods and
// a period change in the middle of a bit. Random frames, noise and frame
// begins follow under several timing settings, the extremes among them.
// The request side pauses at random and the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
	import urx_pkg::*;

	localparam int unsigned HalfPeriod  = 5;
	localparam int unsigned DrainCycles = 6;
	localparam int unsigned WatchdogMax = 2000;
	localparam int unsigned RandomItems = 240;
	localparam int unsigned RandomSets  = 7;
	localparam int unsigned MinReads    = 48;

	typedef enum int {FRAME_GOOD, FRAME_BAD_START, FRAME_BAD_STOP} frame_kind_t;

	typedef struct {
		outcome_t         outcome;
		logic [ByteW-1:0] data_byte;
	} rx_read_t;

	class urx_scoreboard;
		cfg_t                  timing;
		phase_t                phase;
		logic [WaitTicksW-1:0] ticks;
		logic [BitIdxW-1:0]    nbits;
		logic [ByteW-1:0]      shreg;
		logic                  byte_seen;
		rx_read_t              reads_due[$];
		int unsigned           outcome_hits[5];
		int unsigned           reads_made;
		int unsigned           reads_checked;
		int unsigned           frame_begins;
		int unsigned           errors;

		function new();
			timing = '{BitTicksRst, HalfTicksRst, IdleToRst, StartGapRst};
			byte_seen = 1'b0;
			restart_read();
		endfunction

		function void restart_read();
			phase = PH_IDLE;
			ticks = '0;
			nbits = '0;
			shreg = '0;
		endfunction

		function void bump();
			if (ticks != TickMax) begin
				ticks++;
			end
		endfunction

		function void finish(outcome_t oc, logic [ByteW-1:0] value);
			reads_due.push_back('{oc, value});
			outcome_hits[int'(oc)]++;
			reads_made++;
			restart_read();
		endfunction

		function void write_reg(reg_idx_t idx, logic [ApbDataW-1:0] value);
			case (idx)
			REG_BIT_TICKS:  timing.bit_ticks          = value[BitTicksW-1:0];
			REG_HALF_TICKS: timing.half_bit_ticks     = value[BitTicksW-1:0];
			REG_IDLE_TO:    timing.idle_timeout_ticks = value[WaitTicksW-1:0];
			default:        timing.start_gap_ticks    = value[WaitTicksW-1:0];
			endcase
		endfunction

		// advance the read sequence by one accepted request
		function void take_sample(logic act, logic lvl);
			if (act) begin
				frame_begins++;
				byte_seen = 1'b0;
				restart_read();
			end else begin
				case (phase)
				PH_START: begin
					if (!lvl) begin
						phase = PH_HALF;
						ticks = '0;
					end else if (byte_seen && ticks >= timing.start_gap_ticks) begin
						finish(OC_NO_START, '0);
					end else begin
						bump();
					end
				end
				PH_HALF: begin
					bump();
					if (ticks >= timing.half_bit_ticks) begin
						if (lvl) begin
							finish(OC_BAD_START, '0);
						end else begin
							phase = PH_DATA;
							ticks = '0;
							nbits = '0;
							shreg = '0;
						end
					end
				end
				PH_DATA: begin
					bump();
					if (ticks >= timing.bit_ticks) begin
						shreg[nbits[2:0]] = lvl;
						nbits++;
						ticks = '0;
						if (nbits >= DataBits) begin
							phase = PH_STOP;
						end
					end
				end
				PH_STOP: begin
					bump();
					if (ticks >= timing.bit_ticks) begin
						if (!lvl) begin
							finish(OC_BAD_STOP, '0);
						end else begin
							byte_seen = 1'b1;
							finish(OC_GOOD, shreg);
						end
					end
				end
				default: begin
					if (lvl) begin
						phase = PH_START;
						ticks = '0;
					end else if (ticks >= timing.idle_timeout_ticks) begin
						finish(OC_IDLE_TO, '0);
					end else begin
						bump();
					end
				end
				endcase
			end
		endfunction

		function void check_result(logic [2:0] oc, logic [ByteW-1:0] value);
			rx_read_t want;
			if (reads_due.size() == 0) begin
				$error("result with none expected: outcome %0d, data_byte 0x%02h", oc, value);
				errors++;
			end else begin
				want = reads_due.pop_front();
				reads_checked++;
				if (oc !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, oc);
					errors++;
				end
				if (value !== want.data_byte) begin
					$error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, value);
					errors++;
				end
			end
		endfunction
	endclass

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;    // [0] line_level
	logic                s_tuser  = 1'b0;  // [0] action
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;          // [7:0] data_byte
	logic [2:0]          m_tuser;          // [2:0] outcome
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ApbAddrW-1:0] paddr    = '0;
	logic [ApbDataW-1:0] pwdata   = '0;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	urx_scoreboard sb = new();

	int unsigned burst_left   = 0;
	int unsigned items_sent   = 0;
	int unsigned timing_sets  = 0;
	int unsigned quiet_cycles = 0;
	logic [31:0] rx_cycle     = '0;
	logic [1:0]  rx_mode      = '0;

	uart_receiver_with_timeouts DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #HalfPeriod clk = ~clk;

	// result side: check what is taken, then pick the next ready from the stall mode
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tuser, m_tdata);
		end
		rx_cycle++;
		if (rx_cycle % 96 == 0) begin
			rx_mode = 2'($urandom_range(0, 3));
		end
		case (rx_mode)
		2'd0:    m_tready <= 1'b1;
		2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
		2'd2:    m_tready <= (rx_cycle[2:0] == 3'd0);
		default: m_tready <= rx_cycle[3];
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WatchdogMax) begin
			$display("watchdog: nothing moved for %0d cycles", WatchdogMax);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic send_item(input logic act, input logic lvl);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'b0, lvl};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.take_sample(act, lvl);
		items_sent++;
	endtask

	// hold requests until every pending read is back and the pipeline is empty
	task automatic quiesce();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.reads_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [ApbDataW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic set_timing(input int unsigned bt, input int unsigned ht,
			input int unsigned it, input int unsigned sg);
		quiesce();
		reg_write(REG_BIT_TICKS, bt);
		reg_write(REG_HALF_TICKS, ht);
		reg_write(REG_IDLE_TO, it);
		reg_write(REG_START_GAP, sg);
		timing_sets++;
	endtask

	// one bit period: only the last sample is taken, the others may glitch
	task automatic send_level(input int unsigned n, input logic lvl, input logic jitter);
		for (int unsigned i = 1; i < n; i++) begin
			send_item(1'b0, jitter ? 1'($urandom_range(0, 1)) : lvl);
		end
		send_item(1'b0, lvl);
	endtask

	task automatic send_frame(input logic [7:0] value, input int unsigned idle_n,
			input frame_kind_t kind, input logic jitter);
		int unsigned half_n;
		int unsigned bit_n;
		half_n = (sb.timing.half_bit_ticks == 0) ? 1 : sb.timing.half_bit_ticks;
		bit_n  = (sb.timing.bit_ticks == 0) ? 1 : sb.timing.bit_ticks;
		repeat (idle_n) send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b0);
		send_level(half_n, kind == FRAME_BAD_START, jitter);
		if (kind != FRAME_BAD_START) begin
			for (int i = 0; i < 8; i++) begin
				send_level(bit_n, value[i], jitter);
			end
			send_level(bit_n, kind != FRAME_BAD_STOP, jitter);
		end
	endtask

	task automatic random_episode();
		int unsigned pick;
		int unsigned n;
		int unsigned cap;
		int unsigned k;
		frame_kind_t kind;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			cap = (sb.timing.start_gap_ticks > 40) ? 40 : sb.timing.start_gap_ticks;
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, cap + 4) : $urandom_range(1, 3);
			k = $urandom_range(0, 9);
			kind = (k < 8) ? FRAME_GOOD : (k == 8) ? FRAME_BAD_START : FRAME_BAD_STOP;
			send_frame(8'($urandom), n, kind, 1'($urandom_range(0, 1)));
		end else if (pick < 80) begin
			// hold the line low, at times long enough to run out the idle wait
			cap = (sb.timing.idle_timeout_ticks > 40) ? 40 : sb.timing.idle_timeout_ticks;
			repeat ($urandom_range(1, cap + 3)) send_item(1'b0, 1'b0);
		end else if (pick < 88) begin
			send_item(1'b1, 1'($urandom_range(0, 1)));
		end else if (pick < 96) begin
			repeat ($urandom_range(1, 8)) send_item(1'b0, 1'($urandom_range(0, 1)));
		end else begin
			quiesce();
		end
	endtask

	initial begin
		int unsigned set_end;
		int unsigned bt;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// zero bit and half-bit periods act as one tick; any low idle sample times out
		set_timing(0, 0, 0, 1);
		send_item(1'b0, 1'b0);
		send_frame(8'hA5, 1, FRAME_GOOD, 1'b0);
		repeat (3) send_item(1'b0, 1'b1);
		// frame begin clears the seen byte, so the long gap is allowed
		send_item(1'b1, 1'b1);
		repeat (2) send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);

		// shorten the bit period while the first data bit is under way, then a low stop bit
		set_timing(3, 1, 8, 8);
		send_item(1'b0, 1'b1);
		repeat (2) send_item(1'b0, 1'b0);
		repeat (2) send_item(1'b0, 1'b1);
		quiesce();
		reg_write(REG_BIT_TICKS, 1);
		send_item(1'b0, 1'b1);
		for (int i = 1; i < 8; i++) begin
			send_item(1'b0, i[0]);
		end
		send_item(1'b0, 1'b0);

		for (int s = 0; s < RandomSets; s++) begin
			if (s == 0) begin
				set_timing(1, 1, 1, 0);
			end else begin
				bt = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
				set_timing(bt, $urandom_range(0, bt), $urandom_range(0, 20),
					$urandom_range(0, 30));
			end
			set_end = items_sent + RandomItems / RandomSets;
			while (items_sent < set_end) begin
				random_episode();
			end
		end
		while (sb.reads_made < MinReads) begin
			random_episode();
		end

		// longest periods and waits: a start bit under way is dropped by a frame begin
		set_timing(1023, 1023, 65535, 65535);
		send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b0);
		repeat (20) send_item(1'b0, 1'($urandom_range(0, 1)));
		send_item(1'b1, 1'b1);
		// widest waits with a short bit: a long high gap after a byte is no missed start
		set_timing(2, 1, 65535, 65535);
		send_frame(8'($urandom), 2, FRAME_GOOD, 1'b1);
		repeat (30) send_item(1'b0, 1'b1);
		send_frame(8'($urandom), 0, FRAME_GOOD, 1'b1);
		quiesce();

		$display("summary: %0d requests (%0d frame begins), %0d reads checked, %0d timing sets",
			items_sent, sb.frame_begins, sb.reads_checked, timing_sets);
		$display("summary: good %0d, idle timeout %0d, no start %0d, bad start %0d, bad stop %0d",
			sb.outcome_hits[0], sb.outcome_hits[1], sb.outcome_hits[2],
			sb.outcome_hits[3], sb.outcome_hits[4]);
		if (sb.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
